// File: rtl/core/dsic_pkg.sv
// Shared types, constants and helpers for the sector index codec.
package dsic_pkg;

	// field widths
	localparam int CMD_W = 2;
	localparam int LAY_W = 4;
	localparam int MOD_W = 6;
	localparam int SEN_W = 10;
	localparam int SEC_W = 21;
	localparam int X_W   = 18;
	localparam int Z_W   = 19;
	localparam int ST_W  = 2;

	// register widths and limits
	localparam int LCNT_W = 5;
	localparam int MCNT_W = 7;
	localparam int SCNT_W = 11;
	localparam int SM_W   = 17;
	localparam int LSM_W  = 21;
	localparam logic [LCNT_W-1:0] LCNT_MAX = 5'd16;
	localparam logic [MCNT_W-1:0] MCNT_MAX = 7'd64;
	localparam logic [SCNT_W-1:0] SCNT_MAX = 11'd1024;
	localparam logic [LCNT_W-1:0] LCNT_RST = 5'd5;
	localparam logic [MCNT_W-1:0] MCNT_RST = 7'd20;
	localparam logic [SCNT_W-1:0] SCNT_RST = 11'd448;
	// radix products of the reset counts
	localparam logic [SM_W-1:0]   SM_RST   = 17'd8960;
	localparam logic [LSM_W-1:0]  LSM_RST  = 21'd44800;

	// register map (byte addresses)
	localparam int ADDR_W = 4;
	localparam logic [ADDR_W-1:0] ADDR_LCNT = 4'h0;
	localparam logic [ADDR_W-1:0] ADDR_MCNT = 4'h4;
	localparam logic [ADDR_W-1:0] ADDR_SCNT = 4'h8;

	// geometry at 8 fractional bits
	localparam logic signed [Z_W:0] HZ      = 20'sd179200;
	localparam logic signed [Z_W:0] HX_OUT  = 20'sd85005;
	localparam logic signed [Z_W:0] HX_MID  = 20'sd107932;
	localparam logic signed [Z_W:0] HX_CTR  = 20'sd114560;
	// (v >> 9) / 35 by reciprocal, exact for v >> 9 up to 700
	localparam logic [10:0] RECIP_35 = 11'd1873;
	localparam logic [LAY_W-1:0] LAY_LAST_KNOWN = 4'd4;

	// restoring divider: one quotient bit per cell
	localparam int DIV_STEPS = SEC_W;
	localparam int N_CELLS   = 3 * DIV_STEPS;
	localparam int REM_W     = SCNT_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENC = 2'd0,
		CMD_DEC = 2'd1,
		CMD_LOC = 2'd2,
		CMD_BAD = 2'd3
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_LAYER = 2'd2,
		ST_OUT   = 2'd3
	} status_t;

	// result fields carried alongside the divider
	typedef struct packed {
		logic [SEC_W-1:0] sector;
		logic [LAY_W-1:0] layer;
		logic [MOD_W-1:0] module_idx;
		logic [SEN_W-1:0] sensor;
		status_t          status;
		logic             dec;
		logic [SEN_W-1:0] dsen;
		logic [MOD_W-1:0] dmod;
	} pay_t;

	// word handed from cell to cell
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [SEC_W-1:0] dq;
		pay_t             pay;
	} div_t;

	// a written 0 counts as 1, larger values saturate
	function automatic logic [SCNT_W-1:0] clamp_cnt(input logic [SCNT_W-1:0] v,
			input logic [SCNT_W-1:0] hi);
		logic [SCNT_W-1:0] r;
		r = v;
		if (v == '0) r = {{(SCNT_W-1){1'b0}}, 1'b1};
		else if (v > hi) r = hi;
		return r;
	endfunction

endpackage

// File: rtl/core/dsic_front.sv
// Front stages: command decode, locate geometry and encode arithmetic.
module dsic_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_v,
	input  logic [79:0]                   in_data,
	input  logic [dsic_pkg::LCNT_W-1:0]   lcnt,
	input  logic [dsic_pkg::MCNT_W-1:0]   mcnt,
	input  logic [dsic_pkg::SCNT_W-1:0]   scnt,
	input  logic [dsic_pkg::SM_W-1:0]     sm,
	input  logic [dsic_pkg::LSM_W-1:0]    lsm,
	output logic                          out_v,
	output dsic_pkg::div_t                out_w
);

	// unpacked input fields
	dsic_pkg::cmd_t                        cmd;
	logic [dsic_pkg::LAY_W-1:0]            lay_i;
	logic [dsic_pkg::MOD_W-1:0]            mod_i;
	logic [dsic_pkg::SEN_W-1:0]            sen_i;
	logic [dsic_pkg::SEC_W-1:0]            sec_i;
	logic signed [dsic_pkg::X_W-1:0]       x_i;
	logic signed [dsic_pkg::Z_W-1:0]       z_i;

	assign cmd   = dsic_pkg::cmd_t'(in_data[1:0]);
	assign lay_i = in_data[5:2];
	assign mod_i = in_data[11:6];
	assign sen_i = in_data[21:12];
	assign sec_i = in_data[42:22];
	assign x_i   = in_data[60:43];
	assign z_i   = in_data[79:61];

	// locate geometry
	logic signed [dsic_pkg::Z_W:0] hx, xw, zw, xo, zo;
	logic                          known, in_box;
	logic [20:0]                   mprod;
	logic [dsic_pkg::MOD_W-1:0]    lmod;
	logic [dsic_pkg::SEN_W-1:0]    lsen;

	always_comb begin
		known = 1'b1;
		case (lay_i)
			4'd0, 4'd4: hx = dsic_pkg::HX_OUT;
			4'd1, 4'd3: hx = dsic_pkg::HX_MID;
			4'd2:       hx = dsic_pkg::HX_CTR;
			default: begin
				hx = dsic_pkg::HX_OUT;
				known = 1'b0;
			end
		endcase
		xw = 20'(x_i);
		zw = 20'(z_i);
		in_box = (zw <= dsic_pkg::HZ) && (zw >= -dsic_pkg::HZ) && (xw <= hx) && (xw >= -hx);
		xo = xw + hx;
		zo = zw + dsic_pkg::HZ;
		mprod = 21'(zo[18:9]) * 21'(dsic_pkg::RECIP_35);
		lmod = {1'b0, mprod[20:16]};
		lsen = {1'b0, xo[17:9]};
	end

	// index selection and status
	logic [dsic_pkg::LAY_W-1:0] lay_c;
	logic [dsic_pkg::MOD_W-1:0] mod_c;
	logic [dsic_pkg::SEN_W-1:0] sen_c;
	dsic_pkg::status_t          st_c;
	logic                       zero_c, bad_c;

	always_comb begin
		lay_c = lay_i;
		mod_c = mod_i;
		sen_c = sen_i;
		zero_c = 1'b0;
		st_c = dsic_pkg::ST_OK;
		unique case (cmd)
			dsic_pkg::CMD_ENC: ;
			dsic_pkg::CMD_DEC: begin
				// sector range is checked in stage 3
				zero_c = 1'b1;
			end
			dsic_pkg::CMD_LOC: begin
				mod_c = lmod;
				sen_c = lsen;
				if (!known) begin
					zero_c = 1'b1;
					st_c = dsic_pkg::ST_LAYER;
				end else if (!in_box) begin
					zero_c = 1'b1;
					st_c = dsic_pkg::ST_OUT;
				end
			end
			default: begin
				lay_c = '0;
				zero_c = 1'b1;
				st_c = dsic_pkg::ST_RANGE;
			end
		endcase
		bad_c = ({1'b0, lay_c} >= lcnt) || ({1'b0, mod_c} >= mcnt)
			|| ({1'b0, sen_c} >= scnt);
		if ((cmd == dsic_pkg::CMD_ENC || cmd == dsic_pkg::CMD_LOC) && !zero_c && bad_c)
			st_c = dsic_pkg::ST_RANGE;
	end

	// stage 1
	logic                       v_s1, zero_s1, dec_s1;
	logic [dsic_pkg::LAY_W-1:0] lay_s1;
	logic [dsic_pkg::MOD_W-1:0] mod_s1;
	logic [dsic_pkg::SEN_W-1:0] sen_s1;
	logic [dsic_pkg::SEC_W-1:0] sec_s1;
	dsic_pkg::status_t          st_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= zero_c;
			dec_s1  <= (cmd == dsic_pkg::CMD_DEC);
			lay_s1  <= lay_c;
			mod_s1  <= mod_c;
			sen_s1  <= sen_c;
			sec_s1  <= sec_i;
			st_s1   <= st_c;
		end
	end

	// stage 2: partial products
	logic                       v_s2, zero_s2, dec_s2;
	logic [dsic_pkg::LAY_W-1:0] lay_s2;
	logic [dsic_pkg::MOD_W-1:0] mod_s2;
	logic [dsic_pkg::SEN_W-1:0] sen_s2;
	logic [dsic_pkg::SEC_W-1:0] sec_s2;
	dsic_pkg::status_t          st_s2;
	logic [16:0]                pms_s2;
	logic [21:0]                pl_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= zero_s1;
			dec_s2  <= dec_s1;
			lay_s2  <= lay_s1;
			mod_s2  <= mod_s1;
			sen_s2  <= sen_s1;
			sec_s2  <= sec_s1;
			st_s2   <= st_s1;
			pms_s2  <= 17'(mod_s1) * 17'(scnt);
			pl_s2   <= 22'(5'({1'b0, lay_s1} + lcnt)) * 22'(sm);
		end
	end

	// stage 3: sum, decode range check and divider feed
	logic [21:0] sum;
	logic        dec_bad;
	assign sum = pl_s2 + 22'(pms_s2) + 22'(sen_s2);
	assign dec_bad = dec_s2 && ({1'b0, sec_s2} >= {lsm, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_w.rem            <= '0;
			out_w.dq             <= sec_s2;
			out_w.pay.sector     <= zero_s2 ? '0 : sum[20:0];
			out_w.pay.layer      <= lay_s2;
			out_w.pay.module_idx <= zero_s2 ? '0 : mod_s2;
			out_w.pay.sensor     <= zero_s2 ? '0 : sen_s2;
			out_w.pay.status     <= dec_bad ? dsic_pkg::ST_RANGE : st_s2;
			out_w.pay.dec        <= dec_s2;
			out_w.pay.dsen       <= '0;
			out_w.pay.dmod       <= '0;
		end
	end

endmodule

// File: rtl/core/dsic_div_cell.sv
// One restoring division step: shifts one dividend bit in, one quotient bit out.
module dsic_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_v,
	input  dsic_pkg::div_t              in_w,
	input  logic [dsic_pkg::REM_W-1:0]  divisor,
	output logic                        out_v,
	output dsic_pkg::div_t              out_w
);

	logic [dsic_pkg::REM_W:0]   trial;
	logic                       qbit;
	logic [dsic_pkg::REM_W-1:0] rem_n;

	// trial subtract
	always_comb begin
		trial = {in_w.rem, in_w.dq[dsic_pkg::SEC_W-1]};
		qbit  = (trial >= {1'b0, divisor});
		rem_n = qbit ? dsic_pkg::REM_W'(trial - {1'b0, divisor})
			: trial[dsic_pkg::REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v <= 1'b0;
		end else if (en) begin
			out_v <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_w.rem <= rem_n;
			out_w.dq  <= {in_w.dq[dsic_pkg::SEC_W-2:0], qbit};
			out_w.pay <= in_w.pay;
		end
	end

endmodule

// File: rtl/core/detector_sector_index_codec.sv
// Sector index codec top level: register port, front stages, divider chain, output.
//
// Input words arrive on s_tvalid/s_tready/s_tdata; each carries a command
// (encode indices, decode sector, locate from position) and its operands.
// One result word leaves on m_tvalid/m_tready/m_tdata for every input word,
// in order. Layer, module and sensor counts are set over the APB port and
// must only change while no word is in flight.
// The pipeline has three front stages (geometry, products, sum), 63
// divider cells (21 each for the sensor, module and layer radices, one
// quotient bit per cell) and the output register.
// Throughput is one word per cycle while s_tready is high; every cell takes a new
// word each cycle. When the receiver stalls, the output register holds its word
// and one more word drops into a skid register; only then does the whole pipeline
// freeze and s_tready go low. Reset empties the pipeline and restores the counts to
// 5 layers, 20 modules and 448 sensors.
module detector_sector_index_codec (
	input  logic        clk,
	input  logic        arst_n,
	// APB register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // cmd, layer_in, module_in, sensor_in, sector_in, x_pos, z_pos
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // sector_out, layer_out, module_out, sensor_out, status, zero pad
);

	// configuration registers
	logic [dsic_pkg::LCNT_W-1:0] lcnt_q;
	logic [dsic_pkg::MCNT_W-1:0] mcnt_q;
	logic [dsic_pkg::SCNT_W-1:0] scnt_q;
	logic [dsic_pkg::SM_W-1:0]   sm_q;
	logic [dsic_pkg::LSM_W-1:0]  lsm_q;
	logic                        wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcnt_q <= dsic_pkg::LCNT_RST;
			mcnt_q <= dsic_pkg::MCNT_RST;
			scnt_q <= dsic_pkg::SCNT_RST;
			sm_q   <= dsic_pkg::SM_RST;
			lsm_q  <= dsic_pkg::LSM_RST;
		end else begin
			if (wr && paddr == dsic_pkg::ADDR_LCNT)
				lcnt_q <= dsic_pkg::LCNT_W'(dsic_pkg::clamp_cnt(11'(pwdata[4:0]),
					11'(dsic_pkg::LCNT_MAX)));
			if (wr && paddr == dsic_pkg::ADDR_MCNT)
				mcnt_q <= dsic_pkg::MCNT_W'(dsic_pkg::clamp_cnt(11'(pwdata[6:0]),
					11'(dsic_pkg::MCNT_MAX)));
			if (wr && paddr == dsic_pkg::ADDR_SCNT)
				scnt_q <= dsic_pkg::clamp_cnt(pwdata[10:0], dsic_pkg::SCNT_MAX);
			// derived radix products
			sm_q  <= dsic_pkg::SM_W'(17'(scnt_q) * 17'(mcnt_q));
			lsm_q <= dsic_pkg::LSM_W'(21'(sm_q) * 21'(lcnt_q));
		end
	end

	// register read
	always_comb begin
		unique case (paddr)
			dsic_pkg::ADDR_LCNT: prdata = 32'(lcnt_q);
			dsic_pkg::ADDR_MCNT: prdata = 32'(mcnt_q);
			dsic_pkg::ADDR_SCNT: prdata = 32'(scnt_q);
			default:             prdata = '0;
		endcase
	end

	// pipeline enable from skid occupancy
	logic   en;
	logic   skid_v_q, out_v_q;
	dsic_pkg::pay_t skid_q, out_q;

	assign en = !skid_v_q;
	assign s_tready = en;

	// front stages
	logic           v [0:dsic_pkg::N_CELLS];
	dsic_pkg::div_t w [0:dsic_pkg::N_CELLS];

	dsic_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (s_tvalid),
		.in_data (s_tdata),
		.lcnt    (lcnt_q),
		.mcnt    (mcnt_q),
		.scnt    (scnt_q),
		.sm      (sm_q),
		.lsm     (lsm_q),
		.out_v   (v[0]),
		.out_w   (w[0])
	);

	// divider chain: sensor radix, then module radix, then layer radix
	genvar k;
	generate
		for (k = 0; k < dsic_pkg::N_CELLS; k++) begin : g_cell
			dsic_pkg::div_t             cin;
			logic [dsic_pkg::REM_W-1:0] dvs;

			always_comb begin
				cin = w[k];
				if (k == dsic_pkg::DIV_STEPS) begin
					cin.pay.dsen = w[k].rem[dsic_pkg::SEN_W-1:0];
					cin.rem = '0;
				end else if (k == 2 * dsic_pkg::DIV_STEPS) begin
					cin.pay.dmod = w[k].rem[dsic_pkg::MOD_W-1:0];
					cin.rem = '0;
				end
				if (k < dsic_pkg::DIV_STEPS) dvs = scnt_q;
				else if (k < 2 * dsic_pkg::DIV_STEPS) dvs = dsic_pkg::REM_W'(mcnt_q);
				else dvs = dsic_pkg::REM_W'(lcnt_q);
			end

			dsic_div_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.in_v    (v[k]),
				.in_w    (cin),
				.divisor (dvs),
				.out_v   (v[k+1]),
				.out_w   (w[k+1])
			);
		end
	endgenerate

	// final result word
	dsic_pkg::pay_t res;
	always_comb begin
		res = w[dsic_pkg::N_CELLS].pay;
		if (res.dec) begin
			res.layer      = w[dsic_pkg::N_CELLS].rem[dsic_pkg::LAY_W-1:0];
			res.module_idx = res.dmod;
			res.sensor     = res.dsen;
		end
	end

	// output register and skid register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v[dsic_pkg::N_CELLS];
			end
		end else if (v[dsic_pkg::N_CELLS] && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (en) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'd0, out_q.status, out_q.sensor, out_q.module_idx, out_q.layer,
		out_q.sector};

endmodule

// File: rtl/core/dsic_checker.sv
// Port-level checks for the sector index codec, bound to the top level.
module dsic_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// nothing leaves once reset has been seen
	a_rst: assert property (@(posedge clk) !arst_n |=> !m_tvalid)
		else $error("result valid during reset");

	// position outside clears the sector, module and sensor indices
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[42:41] == dsic_pkg::ST_OUT |-> m_tdata[20:0] == 21'd0
			&& m_tdata[40:25] == 16'd0)
		else $error("outside position with non-zero indices");

	// unknown layer only for layers past the last known one
	a_lay: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[42:41] == dsic_pkg::ST_LAYER
			|-> m_tdata[24:21] > dsic_pkg::LAY_LAST_KNOWN && m_tdata[20:0] == 21'd0)
		else $error("unknown layer status on a known layer");

	// register port never waits
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind detector_sector_index_codec dsic_checker u_dsic_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
